// ----- hw/rtl/adc_average_scale_to_digits_macros.svh -----
// ----------------------------------------------------------------------------
// adc_average_scale_to_digits assertion macros
// shared assertion forms for the averaging and digit conversion block
// ----------------------------------------------------------------------------
`ifndef ADC_AVERAGE_SCALE_TO_DIGITS_MACROS_SVH
`define ADC_AVERAGE_SCALE_TO_DIGITS_MACROS_SVH

// checked on every edge out of reset
`define AAS_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define AAS_CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/adc_avg_pkg.sv -----
// ----------------------------------------------------------------------------
// adc_avg_pkg
// widths, register indexes, microcode program and segment table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adc_avg_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int MAX_SAMPLES_DEF = 64;

  localparam int SUM_W      = 16;
  localparam int CNT_W      = 7;
  localparam int GAIN_W     = 12;
  localparam int AVG_W      = 10;
  localparam int SCALED_W   = 22;
  localparam int DIGIT_W    = 4;
  localparam int SEG_W      = 8;
  localparam int DIV_BITS   = 22;
  localparam int DIVCNT_W   = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int USER_W     = 1;

  localparam int OUT_FIELDS_W = AVG_W + SCALED_W + 3 * DIGIT_W + 3 * SEG_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  localparam logic [DIVCNT_W-1:0] DIV_LAST   = DIVCNT_W'(DIV_BITS - 1);
  localparam logic [DIGIT_W-1:0]  DIGIT_MAX  = DIGIT_W'(9);

  // x / 10 as (x * TEN_RECIP) >> RECIP_SHIFT, exact for x below 2**22
  localparam int          RECIP_SHIFT = 23;
  localparam logic [19:0] TEN_RECIP   = 20'd838861;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_SAMPLES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURR_SAMPLES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_DIVISOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURR_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CURR_DIVISOR = 3'd5;

  // register reset values
  localparam logic [CNT_W-1:0]  VOLT_SAMPLES_RST = 7'd64;
  localparam logic [CNT_W-1:0]  CURR_SAMPLES_RST = 7'd32;
  localparam logic [GAIN_W-1:0] VOLT_GAIN_RST    = 12'd230;
  localparam logic [GAIN_W-1:0] VOLT_DIVISOR_RST = 12'd140;
  localparam logic [GAIN_W-1:0] CURR_GAIN_RST    = 12'd1000;
  localparam logic [GAIN_W-1:0] CURR_DIVISOR_RST = 12'd170;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_DIV,
    OP_AVG,
    OP_MUL,
    OP_SCALE,
    OP_TEN,
    OP_ONES,
    OP_TENS,
    OP_HUND,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_NO_FIRE,
    HOLD_DIV_BUSY,
    HOLD_OUT_FULL
  } hold_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t   op;
    hold_t hold;
    pc_t   next;
  } uword_t;

  localparam pc_t STEP_WAIT   = 4'd0;
  localparam pc_t STEP_DIV_A  = 4'd1;
  localparam pc_t STEP_AVG    = 4'd2;
  localparam pc_t STEP_MUL    = 4'd3;
  localparam pc_t STEP_DIV_S  = 4'd4;
  localparam pc_t STEP_SCALE  = 4'd5;
  localparam pc_t STEP_TEN_O  = 4'd6;
  localparam pc_t STEP_ONES   = 4'd7;
  localparam pc_t STEP_TEN_T  = 4'd8;
  localparam pc_t STEP_TENS   = 4'd9;
  localparam pc_t STEP_TEN_H  = 4'd10;
  localparam pc_t STEP_HUND   = 4'd11;
  localparam pc_t STEP_EMIT   = 4'd12;

  // control store: one word per step
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    case (pc)
      STEP_WAIT:  w = '{op: OP_WAIT,  hold: HOLD_NO_FIRE,  next: STEP_DIV_A};
      STEP_DIV_A: w = '{op: OP_DIV,   hold: HOLD_DIV_BUSY, next: STEP_AVG};
      STEP_AVG:   w = '{op: OP_AVG,   hold: HOLD_NONE,     next: STEP_MUL};
      STEP_MUL:   w = '{op: OP_MUL,   hold: HOLD_NONE,     next: STEP_DIV_S};
      STEP_DIV_S: w = '{op: OP_DIV,   hold: HOLD_DIV_BUSY, next: STEP_SCALE};
      STEP_SCALE: w = '{op: OP_SCALE, hold: HOLD_NONE,     next: STEP_TEN_O};
      STEP_TEN_O: w = '{op: OP_TEN,   hold: HOLD_NONE,     next: STEP_ONES};
      STEP_ONES:  w = '{op: OP_ONES,  hold: HOLD_NONE,     next: STEP_TEN_T};
      STEP_TEN_T: w = '{op: OP_TEN,   hold: HOLD_NONE,     next: STEP_TENS};
      STEP_TENS:  w = '{op: OP_TENS,  hold: HOLD_NONE,     next: STEP_TEN_H};
      STEP_TEN_H: w = '{op: OP_TEN,   hold: HOLD_NONE,     next: STEP_HUND};
      STEP_HUND:  w = '{op: OP_HUND,  hold: HOLD_NONE,     next: STEP_EMIT};
      STEP_EMIT:  w = '{op: OP_EMIT,  hold: HOLD_OUT_FULL, next: STEP_WAIT};
      default:    w = '{op: OP_WAIT,  hold: HOLD_NONE,     next: STEP_WAIT};
    endcase
    return w;
  endfunction

  // active-low segments, bit 7 set
  function automatic logic [SEG_W-1:0] seg_pattern(logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0:    p = 8'h81;
      4'd1:    p = 8'hCF;
      4'd2:    p = 8'h92;
      4'd3:    p = 8'h86;
      4'd4:    p = 8'hCC;
      4'd5:    p = 8'hA4;
      4'd6:    p = 8'hA0;
      4'd7:    p = 8'h8F;
      4'd8:    p = 8'h80;
      4'd9:    p = 8'h84;
      default: p = 8'hFF;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/adc_average_scale_to_digits.sv -----
// ----------------------------------------------------------------------------
// adc_average_scale_to_digits
// per-channel sample averager with gain/divisor scaling and decimal digits
// ----------------------------------------------------------------------------
// Samples arrive tagged with a channel (0 voltage, 1 current); each channel
// sums its samples until its configured count is reached, then the block
// averages, scales by gain/divisor, splits the result into hundreds, tens and
// ones with their seven-segment patterns, and sends one output beat. A sample
// that does not complete a block is taken while the input stays ready. A
// completing sample stalls the input while a short microcode program runs
// two divisions (average and scaling) on one shared bit-serial divider, then
// three divide-by-ten steps done by reciprocal multiplication give the digits.
// A finished result waits in the output register while the next samples are
// taken; a completing sample that finds it still full stalls at the emit step
// until the beat is taken.
`timescale 1ns / 1ps
`include "adc_average_scale_to_digits_macros.svh"

module adc_average_scale_to_digits #(
  parameter int SAMPLE_BITS = adc_avg_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_SAMPLES = adc_avg_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // sample stream
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample
  input  logic [adc_avg_pkg::USER_W-1:0]          s_tuser,  // channel
  // result stream
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // average, scaled, digit_hundreds, digit_tens, digit_ones,
  // seg_hundreds, seg_tens, seg_ones
  output logic [adc_avg_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [adc_avg_pkg::USER_W-1:0]          m_tuser,  // out_channel
  // register writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [adc_avg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [adc_avg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int TGT_W = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (TGT_W > adc_avg_pkg::CNT_W) ? TGT_W : adc_avg_pkg::CNT_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_SAMPLES);
  localparam int DB = adc_avg_pkg::DIV_BITS;
  localparam int GW = adc_avg_pkg::GAIN_W;
  localparam int TP_W = adc_avg_pkg::RECIP_SHIFT + DB;

  // configuration
  logic [adc_avg_pkg::CNT_W-1:0] volt_samples;
  logic [adc_avg_pkg::CNT_W-1:0] curr_samples;
  logic [GW-1:0]                 volt_gain;
  logic [GW-1:0]                 volt_divisor;
  logic [GW-1:0]                 curr_gain;
  logic [GW-1:0]                 curr_divisor;

  // channel state
  logic [adc_avg_pkg::SUM_W-1:0] channel_sum   [2];
  logic [adc_avg_pkg::CNT_W-1:0] channel_count [2];

  // sequencer and datapath
  adc_avg_pkg::pc_t              pc;
  adc_avg_pkg::pc_t              pc_next;
  adc_avg_pkg::uword_t           uword;
  logic                          ch;
  logic [GW-1:0]                 div_rem;
  logic [DB-1:0]                 div_quo;
  logic [GW-1:0]                 div_den;
  logic [adc_avg_pkg::DIVCNT_W-1:0] div_cnt;
  logic [adc_avg_pkg::AVG_W-1:0]    avg;
  logic [adc_avg_pkg::SCALED_W-1:0] scaled;
  logic [adc_avg_pkg::DIGIT_W-1:0]  dig_ones;
  logic [adc_avg_pkg::DIGIT_W-1:0]  dig_tens;
  logic [adc_avg_pkg::DIGIT_W-1:0]  dig_hund;

  logic                          in_ch;
  logic [SAMPLE_BITS-1:0]        in_smp;
  logic                          fire;
  logic [adc_avg_pkg::SUM_W-1:0] sum_new;
  logic [adc_avg_pkg::CNT_W-1:0] cnt_new;
  logic [adc_avg_pkg::CNT_W-1:0] samples_sel;
  logic [CMP_W-1:0]              target;
  logic                          complete;
  logic [GW:0]                   rem_shift;
  logic                          rem_ge;
  logic [GW:0]                   rem_diff;
  logic [GW-1:0]                 rem_step;
  logic [GW-1:0]                 gain_sel;
  logic [GW-1:0]                 den_sel;
  logic [DB-1:0]                 product;
  logic [TP_W-1:0]               ten_prod;
  logic [DB-1:0]                 ten_quo;
  logic [DB-1:0]                 ten_back;
  logic [adc_avg_pkg::DIGIT_W-1:0] ten_rem;
  logic                          out_free;
  logic                          hold;

  logic                          div_step;
  logic                          avg_step;
  logic                          emit_step;
  logic                          digits_ok;
  logic                          seq_idle;

  assign uword     = adc_avg_pkg::ucode(pc);
  assign s_tready  = (uword.op == adc_avg_pkg::OP_WAIT);
  assign cfg_ready = 1'b1;

  assign in_ch  = s_tuser[0];
  assign in_smp = s_tdata[SAMPLE_BITS-1:0];
  assign fire   = s_tvalid && s_tready;

  assign sum_new     = channel_sum[in_ch] + adc_avg_pkg::SUM_W'(in_smp);
  assign cnt_new     = channel_count[in_ch] + 1'b1;
  assign samples_sel = in_ch ? curr_samples : volt_samples;

  always_comb begin
    if (samples_sel == '0) begin
      target = CMP_W'(1);
    end else if (CMP_W'(samples_sel) > MAX_CMP) begin
      target = MAX_CMP;
    end else begin
      target = CMP_W'(samples_sel);
    end
  end

  assign complete = (cnt_new == '0) || (CMP_W'(cnt_new) >= target);

  // restoring divider, one quotient bit per cycle
  assign rem_shift = {div_rem, div_quo[DB-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_den};
  assign rem_diff  = rem_shift - {1'b0, div_den};
  assign rem_step  = rem_ge ? rem_diff[GW-1:0] : rem_shift[GW-1:0];

  // divide by ten through the reciprocal, remainder by shift and subtract
  assign ten_prod = TP_W'(div_quo) * TP_W'(adc_avg_pkg::TEN_RECIP);
  assign ten_quo  = ten_prod[adc_avg_pkg::RECIP_SHIFT +: DB];
  assign ten_back = {ten_quo[DB-4:0], 3'b000} + {ten_quo[DB-2:0], 1'b0};
  assign ten_rem  = adc_avg_pkg::DIGIT_W'(div_quo - ten_back);

  assign gain_sel = ch ? curr_gain : volt_gain;
  always_comb begin
    den_sel = ch ? curr_divisor : volt_divisor;
    if (den_sel == '0) begin
      den_sel = GW'(1);
    end
  end
  assign product = DB'(avg) * DB'(gain_sel);

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (uword.hold)
      adc_avg_pkg::HOLD_NONE:     hold = 1'b0;
      adc_avg_pkg::HOLD_NO_FIRE:  hold = !(fire && complete);
      adc_avg_pkg::HOLD_DIV_BUSY: hold = (div_cnt != adc_avg_pkg::DIV_LAST);
      adc_avg_pkg::HOLD_OUT_FULL: hold = !out_free;
      default:                    hold = 1'b0;
    endcase
    pc_next = hold ? pc : uword.next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc               <= adc_avg_pkg::STEP_WAIT;
      m_tvalid         <= 1'b0;
      volt_samples     <= adc_avg_pkg::VOLT_SAMPLES_RST;
      curr_samples     <= adc_avg_pkg::CURR_SAMPLES_RST;
      volt_gain        <= adc_avg_pkg::VOLT_GAIN_RST;
      volt_divisor     <= adc_avg_pkg::VOLT_DIVISOR_RST;
      curr_gain        <= adc_avg_pkg::CURR_GAIN_RST;
      curr_divisor     <= adc_avg_pkg::CURR_DIVISOR_RST;
      channel_sum[0]   <= '0;
      channel_sum[1]   <= '0;
      channel_count[0] <= '0;
      channel_count[1] <= '0;
    end else begin
      pc <= pc_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          adc_avg_pkg::REG_VOLT_SAMPLES: volt_samples <= cfg_data[adc_avg_pkg::CNT_W-1:0];
          adc_avg_pkg::REG_CURR_SAMPLES: curr_samples <= cfg_data[adc_avg_pkg::CNT_W-1:0];
          adc_avg_pkg::REG_VOLT_GAIN:    volt_gain    <= cfg_data;
          adc_avg_pkg::REG_VOLT_DIVISOR: volt_divisor <= cfg_data;
          adc_avg_pkg::REG_CURR_GAIN:    curr_gain    <= cfg_data;
          adc_avg_pkg::REG_CURR_DIVISOR: curr_divisor <= cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && uword.op != adc_avg_pkg::OP_EMIT) begin
        m_tvalid <= 1'b0;
      end

      case (uword.op)
        adc_avg_pkg::OP_WAIT: begin
          if (fire) begin
            channel_sum[in_ch]   <= complete ? '0 : sum_new;
            channel_count[in_ch] <= complete ? '0 : cnt_new;
            ch      <= in_ch;
            div_quo <= DB'(sum_new);
            div_den <= (cnt_new == '0) ? GW'(1) : GW'(cnt_new);
            div_rem <= '0;
            div_cnt <= '0;
          end
        end
        adc_avg_pkg::OP_DIV: begin
          div_rem <= rem_step;
          div_quo <= {div_quo[DB-2:0], rem_ge};
          div_cnt <= div_cnt + 1'b1;
        end
        adc_avg_pkg::OP_AVG: begin
          avg <= div_quo[adc_avg_pkg::AVG_W-1:0];
        end
        adc_avg_pkg::OP_MUL: begin
          div_quo <= product;
          div_den <= den_sel;
          div_rem <= '0;
          div_cnt <= '0;
        end
        adc_avg_pkg::OP_SCALE: begin
          scaled <= div_quo[adc_avg_pkg::SCALED_W-1:0];
        end
        adc_avg_pkg::OP_TEN: begin
          div_quo <= ten_quo;
          div_rem <= GW'(ten_rem);
        end
        adc_avg_pkg::OP_ONES: begin
          dig_ones <= div_rem[adc_avg_pkg::DIGIT_W-1:0];
        end
        adc_avg_pkg::OP_TENS: begin
          dig_tens <= div_rem[adc_avg_pkg::DIGIT_W-1:0];
        end
        adc_avg_pkg::OP_HUND: begin
          dig_hund <= div_rem[adc_avg_pkg::DIGIT_W-1:0];
        end
        adc_avg_pkg::OP_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= ch;
            m_tdata  <= {{adc_avg_pkg::OUT_PAD_W{1'b0}},
                         adc_avg_pkg::seg_pattern(dig_ones),
                         adc_avg_pkg::seg_pattern(dig_tens),
                         adc_avg_pkg::seg_pattern(dig_hund),
                         dig_ones, dig_tens, dig_hund, scaled, avg};
          end
        end
        default: ;
      endcase
    end
  end

  assign div_step  = (uword.op == adc_avg_pkg::OP_DIV);
  assign avg_step  = (pc == adc_avg_pkg::STEP_AVG);
  assign emit_step = (uword.op == adc_avg_pkg::OP_EMIT);
  assign digits_ok = (dig_ones <= adc_avg_pkg::DIGIT_MAX) &&
                     (dig_tens <= adc_avg_pkg::DIGIT_MAX) &&
                     (dig_hund <= adc_avg_pkg::DIGIT_MAX);
  assign seq_idle  = (pc == adc_avg_pkg::STEP_WAIT) && !m_tvalid;

  `AAS_CHECK(a_div_cnt_range, div_step |-> (div_cnt <= adc_avg_pkg::DIV_LAST), "div count high")
  `AAS_CHECK(a_rem_below_den, avg_step |-> (div_rem < div_den), "remainder not below divisor")
  `AAS_CHECK(a_digits_decimal, emit_step |-> digits_ok, "digit above nine at emit")
  `AAS_CHECK(a_beat_from_emit, $rose(m_tvalid) |-> $past(emit_step), "beat raised outside emit")
  `AAS_CHECK_ALWAYS(a_reset_idle, rst |=> seq_idle, "sequencer not idle after reset")

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for adc_average_scale_to_digits. Samples tagged with a channel
// go in on the sample stream. A cycle-free predictor keeps its own per-channel
// sums, counts and register copies, and it works out each completed average,
// scaled value, digits and segment patterns when a sample is accepted. Each
// result beat is compared field by field with the oldest expected reading.
// Directed beats cover the extremes and the corner cases of the count,
// divisor and gain registers. Random phases follow, each after random register
// writes, with random input gaps and output stalls except in steady phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int IN_W           = ((adc_avg_pkg::SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int DRAIN_CYCLES   = 150;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 1550;

  localparam logic CH_VOLT = 1'b0;
  localparam logic CH_CURR = 1'b1;

  localparam logic [adc_avg_pkg::SEG_W-1:0] SEG_LUT [10] = '{
    8'h81, 8'hCF, 8'h92, 8'h86, 8'hCC, 8'hA4, 8'hA0, 8'h8F, 8'h80, 8'h84
  };

  typedef struct packed {
    logic            ch;
    logic [IN_W-1:0] word;
  } sample_beat_t;

  // m_tdata layout, lowest field last
  typedef struct packed {
    logic [adc_avg_pkg::SEG_W-1:0]    seg_ones;
    logic [adc_avg_pkg::SEG_W-1:0]    seg_tens;
    logic [adc_avg_pkg::SEG_W-1:0]    seg_hund;
    logic [adc_avg_pkg::DIGIT_W-1:0]  dig_ones;
    logic [adc_avg_pkg::DIGIT_W-1:0]  dig_tens;
    logic [adc_avg_pkg::DIGIT_W-1:0]  dig_hund;
    logic [adc_avg_pkg::SCALED_W-1:0] scaled;
    logic [adc_avg_pkg::AVG_W-1:0]    avg;
  } reading_t;

  typedef struct packed {
    logic     ch;
    reading_t r;
  } due_reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [IN_W-1:0]                    s_tdata = '0;   // sample
  logic [adc_avg_pkg::USER_W-1:0]     s_tuser = '0;   // channel
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [adc_avg_pkg::OUT_DATA_W-1:0] m_tdata;        // average, scaled, digits, segments
  logic [adc_avg_pkg::USER_W-1:0]     m_tuser;        // out_channel
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [adc_avg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [adc_avg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  adc_average_scale_to_digits dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [adc_avg_pkg::CNT_W-1:0]  n_cfg    [2] = '{adc_avg_pkg::VOLT_SAMPLES_RST,
                                                   adc_avg_pkg::CURR_SAMPLES_RST};
  logic [adc_avg_pkg::GAIN_W-1:0] gain_cfg [2] = '{adc_avg_pkg::VOLT_GAIN_RST,
                                                   adc_avg_pkg::CURR_GAIN_RST};
  logic [adc_avg_pkg::GAIN_W-1:0] div_cfg  [2] = '{adc_avg_pkg::VOLT_DIVISOR_RST,
                                                   adc_avg_pkg::CURR_DIVISOR_RST};
  logic [adc_avg_pkg::SUM_W-1:0]  acc_sum  [2] = '{16'd0, 16'd0};
  logic [adc_avg_pkg::CNT_W-1:0]  acc_cnt  [2] = '{7'd0, 7'd0};

  sample_beat_t sample_queue [$];
  due_reading_t readings_due [$];
  sample_beat_t in_flight;
  reading_t     seen;

  bit          steady = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned samples_taken = 0;
  int unsigned readings_checked = 0;
  int unsigned readings_predicted = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void apply_reg(logic [adc_avg_pkg::CFG_IDX_W-1:0] idx,
                                    logic [adc_avg_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      adc_avg_pkg::REG_VOLT_SAMPLES: n_cfg[CH_VOLT]    = val[adc_avg_pkg::CNT_W-1:0];
      adc_avg_pkg::REG_CURR_SAMPLES: n_cfg[CH_CURR]    = val[adc_avg_pkg::CNT_W-1:0];
      adc_avg_pkg::REG_VOLT_GAIN:    gain_cfg[CH_VOLT] = val;
      adc_avg_pkg::REG_VOLT_DIVISOR: div_cfg[CH_VOLT]  = val;
      adc_avg_pkg::REG_CURR_GAIN:    gain_cfg[CH_CURR] = val;
      adc_avg_pkg::REG_CURR_DIVISOR: div_cfg[CH_CURR]  = val;
      default: ;
    endcase
  endfunction

  // accumulate one sample; a completed block yields one expected reading
  function automatic void take_sample(sample_beat_t b);
    int unsigned target, divisor, cnt, avg, scl;
    due_reading_t d;
    target = n_cfg[b.ch];
    if (target == 0) target = 1;
    else if (target > adc_avg_pkg::MAX_SAMPLES_DEF) target = adc_avg_pkg::MAX_SAMPLES_DEF;
    divisor = div_cfg[b.ch];
    if (divisor == 0) divisor = 1;
    acc_sum[b.ch] = acc_sum[b.ch] +
                    adc_avg_pkg::SUM_W'(b.word[adc_avg_pkg::SAMPLE_BITS_DEF-1:0]);
    acc_cnt[b.ch] = acc_cnt[b.ch] + 1'b1;
    if (acc_cnt[b.ch] != 0 && acc_cnt[b.ch] < target) return;
    cnt = (acc_cnt[b.ch] == 0) ? 1 : acc_cnt[b.ch];
    avg = (acc_sum[b.ch] / cnt) & 32'h3FF;
    scl = ((avg * gain_cfg[b.ch]) / divisor) & 32'h3F_FFFF;
    d.ch         = b.ch;
    d.r.avg      = adc_avg_pkg::AVG_W'(avg);
    d.r.scaled   = adc_avg_pkg::SCALED_W'(scl);
    d.r.dig_hund = adc_avg_pkg::DIGIT_W'((scl / 100) % 10);
    d.r.dig_tens = adc_avg_pkg::DIGIT_W'((scl / 10) % 10);
    d.r.dig_ones = adc_avg_pkg::DIGIT_W'(scl % 10);
    d.r.seg_hund = SEG_LUT[d.r.dig_hund];
    d.r.seg_tens = SEG_LUT[d.r.dig_tens];
    d.r.seg_ones = SEG_LUT[d.r.dig_ones];
    readings_due.push_back(d);
    readings_predicted++;
    acc_sum[b.ch] = '0;
    acc_cnt[b.ch] = '0;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        take_sample(in_flight);
        samples_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_flight <= sample_queue[0];
          s_tdata <= sample_queue[0].word;
          s_tuser <= sample_queue[0].ch;
          s_tvalid <= 1'b1;
          gap_left <= steady ? 0 : pick_gap();
          void'(sample_queue.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (readings_due.size() == 0) begin
          $display("%0t ns: result beat with no reading expected, channel %0d data %h",
                   $time, m_tuser, m_tdata);
          mismatches++;
        end else begin
          seen = reading_t'(m_tdata[adc_avg_pkg::OUT_FIELDS_W-1:0]);
          check_field("channel", readings_due[0].ch, m_tuser);
          check_field("average", readings_due[0].r.avg, seen.avg);
          check_field("scaled", readings_due[0].r.scaled, seen.scaled);
          check_field("digit_hundreds", readings_due[0].r.dig_hund, seen.dig_hund);
          check_field("digit_tens", readings_due[0].r.dig_tens, seen.dig_tens);
          check_field("digit_ones", readings_due[0].r.dig_ones, seen.dig_ones);
          check_field("seg_hundreds", readings_due[0].r.seg_hund, seen.seg_hund);
          check_field("seg_tens", readings_due[0].r.seg_tens, seen.seg_tens);
          check_field("seg_ones", readings_due[0].r.seg_ones, seen.seg_ones);
          void'(readings_due.pop_front());
          readings_checked++;
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall_left <= pick_gap();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on beats of any kind
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_sample(logic ch, logic [IN_W-1:0] word);
    sample_beat_t b;
    b.ch = ch;
    b.word = word;
    sample_queue.push_back(b);
  endfunction

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic write_reg(logic [adc_avg_pkg::CFG_IDX_W-1:0] idx,
                           logic [adc_avg_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    reg_writes++;
  endtask

  task automatic settle();
    while (sample_queue.size() != 0 || s_tvalid || readings_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [adc_avg_pkg::CFG_DATA_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return adc_avg_pkg::CFG_DATA_W'($urandom_range(65, 127));
    if (r == 2) return adc_avg_pkg::CFG_DATA_W'($urandom);
    if (r < 6) return adc_avg_pkg::CFG_DATA_W'($urandom_range(9, 64));
    return adc_avg_pkg::CFG_DATA_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [adc_avg_pkg::CFG_DATA_W-1:0] pick_factor();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return 12'd4095;
    if (r == 2) return 12'd1;
    if (r < 10) return adc_avg_pkg::CFG_DATA_W'($urandom_range(1, 255));
    return adc_avg_pkg::CFG_DATA_W'($urandom_range(1, 4095));
  endfunction

  function automatic logic [IN_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return IN_W'(1023);
    return IN_W'($urandom_range(0, 1023));
  endfunction

  initial begin
    int unsigned phase_len, queued, phases;
    logic [adc_avg_pkg::CFG_IDX_W-1:0] idx;
    queued = 0;
    phases = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-sample voltage blocks at full gain, current divisor zero
    write_reg(adc_avg_pkg::REG_VOLT_SAMPLES, 12'd1);
    write_reg(adc_avg_pkg::REG_CURR_SAMPLES, 12'd2);
    write_reg(adc_avg_pkg::REG_VOLT_GAIN, 12'd4095);
    write_reg(adc_avg_pkg::REG_VOLT_DIVISOR, 12'd1);
    write_reg(adc_avg_pkg::REG_CURR_GAIN, 12'd1);
    write_reg(adc_avg_pkg::REG_CURR_DIVISOR, 12'd0);
    cfg_valid <= 1'b0;
    queue_sample(CH_VOLT, 16'd1023);
    queue_sample(CH_VOLT, 16'd0);
    queue_sample(CH_CURR, 16'd999);
    queue_sample(CH_CURR, 16'd999);
    queue_sample(CH_VOLT, 16'hFC05);
    settle();

    // count zero acts as one, gain zero, tiny scale
    write_reg(adc_avg_pkg::REG_VOLT_SAMPLES, 12'd0);
    write_reg(adc_avg_pkg::REG_CURR_SAMPLES, 12'd3);
    write_reg(adc_avg_pkg::REG_VOLT_GAIN, 12'd1);
    write_reg(adc_avg_pkg::REG_VOLT_DIVISOR, 12'd4095);
    write_reg(adc_avg_pkg::REG_CURR_GAIN, 12'd0);
    write_reg(adc_avg_pkg::REG_CURR_DIVISOR, 12'd140);
    cfg_valid <= 1'b0;
    queue_sample(CH_VOLT, 16'd512);
    queue_sample(CH_CURR, 16'd700);
    queue_sample(CH_CURR, 16'd800);
    settle();

    // current count lowered to what is already held, voltage count above the limit
    write_reg(adc_avg_pkg::REG_VOLT_SAMPLES, 12'd127);
    write_reg(adc_avg_pkg::REG_CURR_SAMPLES, 12'd2);
    write_reg(adc_avg_pkg::REG_CURR_GAIN, 12'd4095);
    write_reg(adc_avg_pkg::REG_CURR_DIVISOR, 12'd4095);
    cfg_valid <= 1'b0;
    queue_sample(CH_CURR, 16'd1000);
    queue_sample(CH_CURR, 16'd1023);
    queue_sample(CH_CURR, 16'd1023);
    queue_sample(CH_VOLT, 16'd1023);
    queue_sample(CH_VOLT, 16'd1);
    queue_sample(CH_VOLT, 16'd1022);
    settle();

    while (queued < RANDOM_ITEMS) begin
      for (int i = 0; i < 6; i++) begin
        idx = adc_avg_pkg::CFG_IDX_W'(i);
        if (phases == 0 || $urandom_range(0, 1) == 1)
          write_reg(idx, (idx == adc_avg_pkg::REG_VOLT_SAMPLES ||
                          idx == adc_avg_pkg::REG_CURR_SAMPLES) ?
                    pick_count() : pick_factor());
      end
      cfg_valid <= 1'b0;
      steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 120);
      for (int i = 0; i < phase_len; i++)
        queue_sample(1'($urandom_range(0, 1)), pick_sample());
      queued += phase_len;
      phases++;
      settle();
    end

    $display("%0d samples over %0d random phases, %0d register writes", samples_taken,
             phases, reg_writes);
    $display("%0d readings checked against %0d predicted", readings_checked,
             readings_predicted);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/adc_avg_pkg.sv
hw/rtl/adc_average_scale_to_digits.sv
tb/sv/tb.sv
